>>> hw/rtl/fcdma_pkg.sv
`default_nettype none
package fcdma_pkg;
	localparam int NUM_CHANNELS = 4;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_REQ   = 2'd2;
	localparam logic [1:0] OP_TICK  = 2'd3;

	localparam logic [3:0] OFF_STATUS = 4'd8;

	localparam logic [1:0] KIND_ILLEGAL = 2'd3;

	localparam int MODE_AUTOLOAD = 7;
	localparam int MODE_TCSTOP   = 6;
	localparam int MODE_ROTATE   = 4;

	localparam logic [15:0] COUNT_MASK = 16'h3FFF;
	localparam logic [15:0] COUNT_WRAP = 16'hFFFF;

	typedef struct packed {
		logic [1:0] op;
		logic [3:0] reg_offset;
		logic [7:0] write_data;
		logic [1:0] req_channel;
		logic       req_level;
	} item_t;
endpackage
`default_nettype wire

>>> hw/rtl/fcdma_front.sv
`default_nettype none
// Input skid stage: takes a transaction and holds it for the engine.
module fcdma_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  fcdma_pkg::item_t    in_item,
	output logic                q_valid,
	input  wire                 q_ready,
	output fcdma_pkg::item_t    q_item
);
	fcdma_pkg::item_t buf_q [2];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;

	wire push = in_valid && in_ready;
	wire pop  = q_valid && q_ready;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = buf_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= in_item;
	end
endmodule
`default_nettype wire

>>> hw/rtl/fcdma_engine.sv
`default_nettype none
// Executes one transaction per cycle while the output is not stalled, and registers its result.
module fcdma_engine #(
	parameter int NUM_CHANNELS = fcdma_pkg::NUM_CHANNELS
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               q_valid,
	output logic              q_ready,
	input  fcdma_pkg::item_t  q_item,
	output logic              out_valid,
	input  wire               out_ready,
	output logic [7:0]        read_data,
	output logic              hold_request,
	output logic              xfer_valid,
	output logic [1:0]        xfer_channel,
	output logic [15:0]       xfer_address,
	output logic [1:0]        xfer_kind,
	output logic              terminal_count,
	output logic              block_done
);
	localparam int CW = $clog2(NUM_CHANNELS);

	logic [15:0] regs_q [2*NUM_CHANNELS];
	logic [15:0] waddr_q [NUM_CHANNELS];
	logic [15:0] wcnt_q [NUM_CHANNELS];
	logic [1:0]  wkind_q [NUM_CHANNELS];
	logic [7:0]  mode_q;
	logic [NUM_CHANNELS-1:0] tc_q, req_q;
	logic        flip_q;
	logic [CW-1:0] rot_q;

	logic [15:0] regs_d [2*NUM_CHANNELS];
	logic [15:0] waddr_d [NUM_CHANNELS];
	logic [15:0] wcnt_d [NUM_CHANNELS];
	logic [1:0]  wkind_d [NUM_CHANNELS];
	logic [7:0]  mode_d;
	logic [NUM_CHANNELS-1:0] tc_d, req_d;
	logic        flip_d;
	logic [CW-1:0] rot_d;

	logic [7:0]  rd;
	logic        xv, tcp, bd, found;
	logic [CW-1:0] ch, rr, cand;
	logic [NUM_CHANNELS-1:0] elig;
	logic [15:0] newcnt;

	wire go = q_valid && q_ready;
	assign q_ready = !out_valid || out_ready;

	always_comb begin
		regs_d  = regs_q;
		waddr_d = waddr_q;
		wcnt_d  = wcnt_q;
		wkind_d = wkind_q;
		mode_d  = mode_q;
		tc_d    = tc_q;
		req_d   = req_q;
		flip_d  = flip_q;
		rot_d   = rot_q;
		rd      = '0;
		xv      = 1'b0;
		tcp     = 1'b0;
		bd      = 1'b0;
		found   = 1'b0;
		ch      = '0;
		cand    = '0;
		newcnt  = '0;
		rr      = mode_q[fcdma_pkg::MODE_ROTATE] ? rot_q : '0;
		elig    = ~tc_q & req_q & mode_q[NUM_CHANNELS-1:0];
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			cand = rr + CW'(i);
			if (!found && elig[cand]) begin
				found = 1'b1;
				ch    = cand;
			end
		end
		case (q_item.op)
			fcdma_pkg::OP_READ: begin
				if (!q_item.reg_offset[3]) begin
					rd = flip_q ? regs_q[q_item.reg_offset[2:0]][15:8]
						: regs_q[q_item.reg_offset[2:0]][7:0];
					flip_d = ~flip_q;
				end else if (q_item.reg_offset == fcdma_pkg::OFF_STATUS) begin
					rd   = 8'(tc_q);
					tc_d = '0;
				end else begin
					rd = 8'hFF;
				end
			end
			fcdma_pkg::OP_WRITE: begin
				if (!q_item.reg_offset[3]) begin
					if (flip_q)
						regs_d[q_item.reg_offset[2:0]][15:8] = q_item.write_data;
					else
						regs_d[q_item.reg_offset[2:0]] = {8'h00, q_item.write_data};
					// mirror channel 2 into channel 3 under autoload
					if (mode_q[fcdma_pkg::MODE_AUTOLOAD] && q_item.reg_offset[2:1] == 2'd2) begin
						if (flip_q)
							regs_d[{2'd3, q_item.reg_offset[0]}][15:8] = q_item.write_data;
						else
							regs_d[{2'd3, q_item.reg_offset[0]}] = {8'h00, q_item.write_data};
					end
					flip_d = ~flip_q;
				end else if (q_item.reg_offset == fcdma_pkg::OFF_STATUS) begin
					mode_d = q_item.write_data;
					flip_d = 1'b0;
				end
			end
			fcdma_pkg::OP_REQ: begin
				if (q_item.req_level) begin
					req_d[q_item.req_channel]   = 1'b1;
					waddr_d[q_item.req_channel] = regs_q[{q_item.req_channel, 1'b0}];
					wcnt_d[q_item.req_channel]  =
						regs_q[{q_item.req_channel, 1'b1}] & fcdma_pkg::COUNT_MASK;
					wkind_d[q_item.req_channel] = regs_q[{q_item.req_channel, 1'b1}][15:14];
					tc_d[q_item.req_channel]    = 1'b0;
				end else begin
					req_d[q_item.req_channel] = 1'b0;
				end
			end
			fcdma_pkg::OP_TICK: begin
				if (found && wkind_q[ch] != fcdma_pkg::KIND_ILLEGAL) begin
					xv = 1'b1;
					if (wcnt_q[ch] == '0) begin
						tc_d[ch] = 1'b1;
						tcp      = 1'b1;
					end
					newcnt      = wcnt_q[ch] - 16'd1;
					waddr_d[ch] = waddr_q[ch] + 16'd1;
					wcnt_d[ch]  = newcnt;
					rot_d       = ch + CW'(1);
					if (newcnt == fcdma_pkg::COUNT_WRAP) begin
						bd = 1'b1;
						if (ch == CW'(2) && mode_q[fcdma_pkg::MODE_AUTOLOAD]) begin
							regs_d[4] = regs_q[6];
							regs_d[5] = regs_q[7];
						end
						req_d[ch] = 1'b0;
						if (!(mode_q[fcdma_pkg::MODE_AUTOLOAD] && ch == CW'(2))
							&& mode_q[fcdma_pkg::MODE_TCSTOP])
							mode_d[ch] = 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2*NUM_CHANNELS; i++) regs_q[i] <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				waddr_q[i] <= '0;
				wcnt_q[i]  <= '0;
				wkind_q[i] <= '0;
			end
			mode_q    <= '0;
			tc_q      <= '0;
			req_q     <= '0;
			flip_q    <= 1'b0;
			rot_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (go) begin
				regs_q  <= regs_d;
				waddr_q <= waddr_d;
				wcnt_q  <= wcnt_d;
				wkind_q <= wkind_d;
				mode_q  <= mode_d;
				tc_q    <= tc_d;
				req_q   <= req_d;
				flip_q  <= flip_d;
				rot_q   <= rot_d;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			read_data      <= rd;
			hold_request   <= |(req_d & mode_d[NUM_CHANNELS-1:0]);
			xfer_valid     <= xv;
			xfer_channel   <= xv ? 2'(ch) : 2'd0;
			xfer_address   <= xv ? waddr_q[ch] : 16'd0;
			xfer_kind      <= xv ? wkind_q[ch] : 2'd0;
			terminal_count <= tcp;
			block_done     <= bd;
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/four_channel_dma_controller.sv
`default_nettype none
// Channel | handshake          | payload
// in      | in_valid/in_ready  | op, reg_offset, write_data, req_channel, req_level
// out     | out_valid/out_ready| read_data .. block_done
//
// One transaction per cycle while the output is not stalled. Each is registered
// in the skid queue, then in the engine's result register. The engine's state
// update is the only loop. Asynchronous reset clears all channel state to zero.
// A stalled output holds the engine; the two-entry queue takes input until full.
module four_channel_dma_controller #(
	parameter int NUM_CHANNELS = fcdma_pkg::NUM_CHANNELS
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [1:0]  op,
	input  wire  [3:0]  reg_offset,
	input  wire  [7:0]  write_data,
	input  wire  [1:0]  req_channel,
	input  wire         req_level,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [7:0]  read_data,
	output logic        hold_request,
	output logic        xfer_valid,
	output logic [1:0]  xfer_channel,
	output logic [15:0] xfer_address,
	output logic [1:0]  xfer_kind,
	output logic        terminal_count,
	output logic        block_done
);
	fcdma_pkg::item_t in_item, q_item;
	logic q_valid, q_ready;

	assign in_item = '{op: op, reg_offset: reg_offset, write_data: write_data,
		req_channel: req_channel, req_level: req_level};

	fcdma_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	fcdma_engine #(.NUM_CHANNELS(NUM_CHANNELS)) u_engine (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.out_valid(out_valid), .out_ready(out_ready),
		.read_data(read_data), .hold_request(hold_request),
		.xfer_valid(xfer_valid), .xfer_channel(xfer_channel),
		.xfer_address(xfer_address), .xfer_kind(xfer_kind),
		.terminal_count(terminal_count), .block_done(block_done)
	);

	a_tc_needs_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && terminal_count |-> xfer_valid)
		else $error("terminal count without transfer");
	a_done_needs_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && block_done |-> xfer_valid)
		else $error("block done without transfer");
	a_no_kind3: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && xfer_valid |-> xfer_kind != fcdma_pkg::KIND_ILLEGAL)
		else $error("illegal transfer kind issued");
endmodule
`default_nettype wire

>>> tb/tb_four_channel_dma_controller.sv
`timescale 1ns / 100ps
module tb_four_channel_dma_controller;

	localparam int CYCLE_LIMIT = 200000;
	localparam int N_RANDOM    = 700;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        hold_request;
		logic        xfer_valid;
		logic [1:0]  xfer_channel;
		logic [15:0] xfer_address;
		logic [1:0]  xfer_kind;
		logic        terminal_count;
		logic        block_done;
	} xfer_result_t;

	// directed row: item plus optional typed-in expectation
	typedef struct {
		fcdma_pkg::item_t item;
		bit               fixed;
		xfer_result_t     want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = '0;
	logic [3:0] reg_offset = '0;
	logic [7:0] write_data = '0;
	logic [1:0] req_channel = '0;
	logic req_level = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] read_data;
	logic hold_request, xfer_valid, terminal_count, block_done;
	logic [1:0] xfer_channel, xfer_kind;
	logic [15:0] xfer_address;

	four_channel_dma_controller u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.op(op), .reg_offset(reg_offset), .write_data(write_data),
		.req_channel(req_channel), .req_level(req_level),
		.out_valid(out_valid), .out_ready(out_ready), .read_data(read_data),
		.hold_request(hold_request), .xfer_valid(xfer_valid),
		.xfer_channel(xfer_channel), .xfer_address(xfer_address),
		.xfer_kind(xfer_kind), .terminal_count(terminal_count),
		.block_done(block_done)
	);

	always #5 clk = ~clk;

	// shadow controller state
	logic [15:0] sh_regs [8];
	logic [15:0] sh_addr [4];
	logic [15:0] sh_count [4];
	logic [1:0]  sh_kind [4];
	logic [7:0]  sh_mode;
	logic [3:0]  sh_tc;
	logic        sh_flip;
	logic [3:0]  sh_req;
	logic [1:0]  sh_rot;

	xfer_result_t expected_q [$];
	int n_errors = 0;
	int n_results = 0;
	int n_xfers = 0;
	int n_cycles = 0;

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		n_errors++;
		$display("MISMATCH result %0d %s: got %h want %h", n_results, what, got, want);
	endtask

	task automatic load_byte(input logic [2:0] idx, input logic [7:0] b);
		if (sh_flip)
			sh_regs[idx] = {b, sh_regs[idx][7:0]};
		else
			sh_regs[idx] = {8'h00, b};
	endtask

	task automatic predict_dma(input fcdma_pkg::item_t it, output xfer_result_t r);
		logic [1:0] start, ch;
		bit found;
		bit autold;
		r = '0;
		found = 1'b0;
		ch = '0;
		case (it.op)
			fcdma_pkg::OP_READ: begin
				if (it.reg_offset < fcdma_pkg::OFF_STATUS) begin
					r.read_data = sh_flip ? sh_regs[it.reg_offset[2:0]][15:8] :
						sh_regs[it.reg_offset[2:0]][7:0];
					sh_flip = ~sh_flip;
				end else if (it.reg_offset == fcdma_pkg::OFF_STATUS) begin
					r.read_data = {4'h0, sh_tc};
					sh_tc = '0;
				end else begin
					r.read_data = 8'hFF;
				end
			end
			fcdma_pkg::OP_WRITE: begin
				if (it.reg_offset < fcdma_pkg::OFF_STATUS) begin
					load_byte(it.reg_offset[2:0], it.write_data);
					if (sh_mode[fcdma_pkg::MODE_AUTOLOAD]
						&& (it.reg_offset == 4'd4 || it.reg_offset == 4'd5))
						load_byte(it.reg_offset[2:0] + 3'd2, it.write_data);
					sh_flip = ~sh_flip;
				end else if (it.reg_offset == fcdma_pkg::OFF_STATUS) begin
					sh_mode = it.write_data;
					sh_flip = 1'b0;
				end
			end
			fcdma_pkg::OP_REQ: begin
				if (it.req_level) begin
					sh_req[it.req_channel] = 1'b1;
					sh_addr[it.req_channel] = sh_regs[{it.req_channel, 1'b0}];
					sh_count[it.req_channel] =
						sh_regs[{it.req_channel, 1'b1}] & fcdma_pkg::COUNT_MASK;
					sh_kind[it.req_channel] = sh_regs[{it.req_channel, 1'b1}][15:14];
					sh_tc[it.req_channel] = 1'b0;
				end else begin
					sh_req[it.req_channel] = 1'b0;
				end
			end
			default: begin
				start = sh_mode[fcdma_pkg::MODE_ROTATE] ? sh_rot : 2'd0;
				for (int i = 0; i < 4; i++) begin
					ch = start + 2'(i);
					if (!sh_tc[ch] && sh_mode[ch] && sh_req[ch]) begin
						found = 1'b1;
						break;
					end
				end
				if (found && sh_kind[ch] != fcdma_pkg::KIND_ILLEGAL) begin
					r.xfer_valid = 1'b1;
					r.xfer_channel = ch;
					r.xfer_address = sh_addr[ch];
					r.xfer_kind = sh_kind[ch];
					if (sh_count[ch] == 16'h0) begin
						sh_tc[ch] = 1'b1;
						r.terminal_count = 1'b1;
					end
					sh_addr[ch] = sh_addr[ch] + 16'd1;
					sh_count[ch] = sh_count[ch] - 16'd1;
					sh_rot = ch + 2'd1;
					if (sh_count[ch] == fcdma_pkg::COUNT_WRAP) begin
						autold = sh_mode[fcdma_pkg::MODE_AUTOLOAD];
						r.block_done = 1'b1;
						if (ch == 2'd2 && autold) begin
							sh_regs[4] = sh_regs[6];
							sh_regs[5] = sh_regs[7];
						end
						sh_req[ch] = 1'b0;
						if (!(autold && ch == 2'd2) && sh_mode[fcdma_pkg::MODE_TCSTOP])
							sh_mode[ch] = 1'b0;
					end
				end
			end
		endcase
		r.hold_request = |(sh_req & sh_mode[3:0]);
	endtask

	// send one transaction; predicted or typed-in expectation queued on acceptance
	task automatic send_item(input fcdma_pkg::item_t it, input bit fixed,
			input xfer_result_t want);
		xfer_result_t r;
		in_valid <= 1'b1;
		op <= it.op;
		reg_offset <= it.reg_offset;
		write_data <= it.write_data;
		req_channel <= it.req_channel;
		req_level <= it.req_level;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_dma(it, r);
		expected_q.push_back(fixed ? want : r);
		if (r.xfer_valid) n_xfers++;
		@(negedge clk);
	endtask

	int burst_left = 0;
	task automatic pace;
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 4);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
	endtask

	function automatic fcdma_pkg::item_t mk(input logic [1:0] o, input logic [3:0] off,
			input logic [7:0] d, input logic [1:0] c, input logic l);
		fcdma_pkg::item_t it;
		it.op = o;
		it.reg_offset = off;
		it.write_data = d;
		it.req_channel = c;
		it.req_level = l;
		return it;
	endfunction

	// mostly well-formed transactions with random content
	function automatic fcdma_pkg::item_t rand_item;
		int k;
		k = $urandom_range(0, 99);
		if (k < 40)
			return mk(fcdma_pkg::OP_TICK, 4'($urandom), 8'($urandom), 2'($urandom),
				1'($urandom));
		else if (k < 58)
			return mk(fcdma_pkg::OP_WRITE, 4'($urandom_range(0, 7)),
				($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6)),
				2'($urandom), 1'($urandom));
		else if (k < 64)
			return mk(fcdma_pkg::OP_WRITE,
				($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15)) :
				fcdma_pkg::OFF_STATUS, 8'($urandom), 2'($urandom), 1'($urandom));
		else if (k < 82)
			return mk(fcdma_pkg::OP_REQ, 4'($urandom), 8'($urandom), 2'($urandom),
				1'($urandom_range(0, 3) != 0));
		else
			return mk(fcdma_pkg::OP_READ, 4'($urandom), 8'($urandom), 2'($urandom),
				1'($urandom));
	endfunction

	// receiver: stall pattern of its own, compare field by field
	always @(negedge clk) begin
		if (arst_n)
			out_ready <= ((n_cycles / 64) % 3 == 0) ? 1'b1 : ($urandom_range(0, 2) != 0);
	end

	always @(posedge clk) begin
		xfer_result_t w;
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", n_cycles);
			$display("tb_four_channel_dma_controller: done, errors");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (expected_q.size() == 0) begin
				report("unexpected transaction", 16'h0, 16'h0);
			end else begin
				w = expected_q.pop_front();
				if (read_data !== w.read_data)
					report("read_data", 16'(read_data), 16'(w.read_data));
				if (hold_request !== w.hold_request)
					report("hold_request", 16'(hold_request), 16'(w.hold_request));
				if (xfer_valid !== w.xfer_valid)
					report("xfer_valid", 16'(xfer_valid), 16'(w.xfer_valid));
				if (xfer_channel !== w.xfer_channel)
					report("xfer_channel", 16'(xfer_channel), 16'(w.xfer_channel));
				if (xfer_address !== w.xfer_address)
					report("xfer_address", xfer_address, w.xfer_address);
				if (xfer_kind !== w.xfer_kind)
					report("xfer_kind", 16'(xfer_kind), 16'(w.xfer_kind));
				if (terminal_count !== w.terminal_count)
					report("terminal_count", 16'(terminal_count), 16'(w.terminal_count));
				if (block_done !== w.block_done)
					report("block_done", 16'(block_done), 16'(w.block_done));
			end
		end
	end

	row_t rows [$];

	function automatic xfer_result_t rd(input logic [7:0] b);
		xfer_result_t r;
		r = '0;
		r.read_data = b;
		return r;
	endfunction

	initial begin
		row_t row;
		xfer_result_t none;
		none = '0;
		for (int i = 0; i < 8; i++) sh_regs[i] = '0;
		for (int i = 0; i < 4; i++) begin
			sh_addr[i] = '0;
			sh_count[i] = '0;
			sh_kind[i] = '0;
		end
		sh_mode = '0;
		sh_tc = '0;
		sh_flip = 1'b0;
		sh_req = '0;
		sh_rot = '0;

		// after reset: zero registers, unused offset, empty status, idle tick
		rows.push_back('{mk(fcdma_pkg::OP_READ, 4'd0, 8'h00, 2'd0, 1'b0), 1'b1, rd(8'h00)});
		rows.push_back('{mk(fcdma_pkg::OP_READ, 4'd15, 8'h00, 2'd0, 1'b0), 1'b1, rd(8'hFF)});
		rows.push_back('{mk(fcdma_pkg::OP_READ, fcdma_pkg::OFF_STATUS, 8'h00, 2'd0, 1'b0),
			1'b1, rd(8'h00)});
		rows.push_back('{mk(fcdma_pkg::OP_TICK, 4'd0, 8'h00, 2'd0, 1'b0), 1'b1, none});
		// mode write clears the byte flip-flop left high by the first read
		rows.push_back('{mk(fcdma_pkg::OP_WRITE, fcdma_pkg::OFF_STATUS, 8'h00, 2'd0, 1'b0),
			1'b0, none});
		// program channel 0: address FFFF (wraps), count 1, kind 1
		rows.push_back('{mk(fcdma_pkg::OP_WRITE, 4'd0, 8'hFF, 2'd0, 1'b0), 1'b0, none});
		rows.push_back('{mk(fcdma_pkg::OP_WRITE, 4'd0, 8'hFF, 2'd0, 1'b0), 1'b0, none});
		rows.push_back('{mk(fcdma_pkg::OP_WRITE, 4'd1, 8'h01, 2'd0, 1'b0), 1'b0, none});
		rows.push_back('{mk(fcdma_pkg::OP_WRITE, 4'd1, 8'h40, 2'd0, 1'b0), 1'b0, none});
		// channel 1: illegal kind
		rows.push_back('{mk(fcdma_pkg::OP_WRITE, 4'd3, 8'h00, 2'd0, 1'b0), 1'b0, none});
		rows.push_back('{mk(fcdma_pkg::OP_WRITE, 4'd3, 8'hFF, 2'd0, 1'b0), 1'b0, none});
		// mode: autoload, TC stop, rotate, all enabled
		rows.push_back('{mk(fcdma_pkg::OP_WRITE, fcdma_pkg::OFF_STATUS, 8'hFF, 2'd0, 1'b0),
			1'b0, none});
		rows.push_back('{mk(fcdma_pkg::OP_WRITE, 4'd4, 8'hA5, 2'd0, 1'b0), 1'b0, none});
		rows.push_back('{mk(fcdma_pkg::OP_WRITE, 4'd5, 8'h00, 2'd0, 1'b0), 1'b0, none});
		rows.push_back('{mk(fcdma_pkg::OP_REQ, 4'd0, 8'h00, 2'd1, 1'b1), 1'b0, none});
		rows.push_back('{mk(fcdma_pkg::OP_TICK, 4'd0, 8'h00, 2'd0, 1'b0), 1'b0, none});
		rows.push_back('{mk(fcdma_pkg::OP_REQ, 4'd0, 8'h00, 2'd1, 1'b0), 1'b0, none});
		rows.push_back('{mk(fcdma_pkg::OP_REQ, 4'd0, 8'h00, 2'd0, 1'b1), 1'b0, none});
		rows.push_back('{mk(fcdma_pkg::OP_REQ, 4'd0, 8'h00, 2'd2, 1'b1), 1'b0, none});
		for (int i = 0; i < 4; i++)
			rows.push_back('{mk(fcdma_pkg::OP_TICK, 4'd0, 8'h00, 2'd0, 1'b0), 1'b0, none});
		rows.push_back('{mk(fcdma_pkg::OP_READ, fcdma_pkg::OFF_STATUS, 8'h00, 2'd0, 1'b0),
			1'b0, none});
		rows.push_back('{mk(fcdma_pkg::OP_READ, 4'd4, 8'h00, 2'd0, 1'b0), 1'b0, none});
		rows.push_back('{mk(fcdma_pkg::OP_WRITE, 4'd12, 8'h5A, 2'd3, 1'b1), 1'b0, none});

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			row = rows[i];
			pace();
			send_item(row.item, row.fixed, row.want);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			pace();
			send_item(rand_item(), 1'b0, none);
		end
		in_valid <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("ran %0d directed and %0d random transactions, %0d results, %0d transfers",
			rows.size(), N_RANDOM, n_results, n_xfers);
		if (n_errors == 0 && expected_q.size() == 0)
			$display("tb_four_channel_dma_controller: done, clean");
		else
			$display("tb_four_channel_dma_controller: done, errors");
		$finish;
	end
endmodule
